@@ rtl/rapid_trigger_key_actuation_defines.svh @@
// Assertion macros shared by the rapid-trigger key actuation RTL.
`ifndef RAPID_TRIGGER_KEY_ACTUATION_DEFINES_SVH
`define RAPID_TRIGGER_KEY_ACTUATION_DEFINES_SVH

`ifndef SYNTHESIS
// Property that must hold whenever its antecedent holds in the same cycle.
`define RTKA_ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("rapid trigger assertion failed");
// Property whose consequent must hold in the cycle after its antecedent.
`define RTKA_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("rapid trigger assertion failed");
`else
`define RTKA_ASSERT_SAME(label, clk, rst_n, ante, cons)
`define RTKA_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif

`endif

@@ rtl/rtka_pkg.sv @@
// Shared types and constants of the rapid-trigger key actuation block.
package rtka_pkg;

    // Field widths of the sample and result transfers.
    localparam int KEY_W  = 6;
    localparam int DIST_W = 8;
    localparam int DIR_W  = 2;

    // Stream data widths, padded to whole bytes.
    localparam int IN_TDATA_W  = 40;
    localparam int OUT_TDATA_W = 16;

    // Mask for the continuous flag.
    localparam logic CONTINUOUS_BIT = 1'b1;

    // Rapid-trigger direction codes.
    typedef enum logic [DIR_W-1:0] {
        DIR_INACTIVE = 2'd0,
        DIR_DOWN     = 2'd1,
        DIR_UP       = 2'd2
    } dir_t;

    // Per-key state as held in the state memory.
    typedef struct packed {
        logic              pressed;
        logic [DIST_W-1:0] extremum;
        dir_t              direction;
    } key_entry_t;

    localparam int STATE_W = $bits(key_entry_t);

    // Settings that come with each sample.
    typedef struct packed {
        logic [DIST_W-1:0] travel;
        logic [DIST_W-1:0] trip_point;
        logic [DIST_W-1:0] press_delta;
        logic [DIST_W-1:0] release_delta;
        logic              continuous;
    } sample_t;

endpackage

@@ rtl/rtka_ram.sv @@
// Generic single-port-write, single-port-read RAM with registered read data.
module rtka_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write port and registered read port; a read of the address being
    // written returns the old contents.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

@@ rtl/rtka_update.sv @@
// Next-state logic of one key: standard threshold mode and the rapid-trigger machine.
module rtka_update (
    input  rtka_pkg::key_entry_t cur_state,
    input  rtka_pkg::sample_t    sample,
    output rtka_pkg::key_entry_t next_state
);
    import rtka_pkg::*;

    logic [DIST_W-1:0] release_floor;
    logic [DIST_W-1:0] release_step;
    logic              at_reset_point;
    logic              release_hit;
    logic [DIST_W:0]   press_sum;
    logic              press_hit;

    // Reset point and release step follow the per-key settings.
    assign release_floor  = ((sample.continuous & CONTINUOUS_BIT) != 1'b0) ?
                            '0 : sample.trip_point;
    assign release_step   = (sample.release_delta != '0) ?
                            sample.release_delta : sample.press_delta;
    assign at_reset_point = (sample.travel <= release_floor);

    // Came back up far enough from the deepest point.
    assign release_hit = (cur_state.extremum >= release_step) &&
                         (sample.travel <= (cur_state.extremum - release_step));

    // Went down far enough from the shallowest point; the sum does not wrap.
    assign press_sum = {1'b0, cur_state.extremum} + {1'b0, sample.press_delta};
    assign press_hit = (press_sum <= {1'b0, sample.travel});

    always_comb
    begin
        next_state = cur_state;
        if (sample.press_delta == '0)
        begin
            // Standard mode keeps the extremum and goes inactive.
            next_state.pressed   = (sample.travel >= sample.trip_point);
            next_state.direction = DIR_INACTIVE;
        end
        else
        begin
            case (cur_state.direction)
                DIR_DOWN:
                begin
                    if (at_reset_point)
                    begin
                        next_state.extremum  = sample.travel;
                        next_state.direction = DIR_INACTIVE;
                        next_state.pressed   = 1'b0;
                    end
                    else if (release_hit)
                    begin
                        next_state.extremum  = sample.travel;
                        next_state.direction = DIR_UP;
                        next_state.pressed   = 1'b0;
                    end
                    else if (sample.travel > cur_state.extremum)
                    begin
                        next_state.extremum = sample.travel;
                    end
                end
                DIR_UP:
                begin
                    if (at_reset_point)
                    begin
                        next_state.extremum  = sample.travel;
                        next_state.direction = DIR_INACTIVE;
                        next_state.pressed   = 1'b0;
                    end
                    else if (press_hit)
                    begin
                        next_state.extremum  = sample.travel;
                        next_state.direction = DIR_DOWN;
                        next_state.pressed   = 1'b1;
                    end
                    else if (sample.travel < cur_state.extremum)
                    begin
                        next_state.extremum = sample.travel;
                    end
                end
                default:
                begin
                    // Inactive, and the unused code treated the same way.
                    if (sample.travel > sample.trip_point)
                    begin
                        next_state.extremum  = sample.travel;
                        next_state.direction = DIR_DOWN;
                        next_state.pressed   = 1'b1;
                    end
                end
            endcase
        end
    end

endmodule

@@ rtl/rapid_trigger_key_actuation.sv @@
// Rapid-trigger key actuation: per-key state memory with read-modify-write pipeline.
//
// The block takes one key sample per clock cycle while the output side is not stalled
// and returns one result per sample, in order, through stage 1 and the output register.
// Per-key state (direction, extremum, pressed) lives in one synchronous RAM of
// KEY_COUNT entries; the registered read of that RAM sets the depth of the pipeline, and a
// forwarding path from the write of the previous sample keeps back-to-back samples
// of the same key exact. Reset clears the state at once through one valid flag per
// key, so there is no clearing pass. Samples for a key number at or above KEY_COUNT
// change no state and report the key released and inactive.
`include "rapid_trigger_key_actuation_defines.svh"

module rapid_trigger_key_actuation #(
    parameter int KEY_COUNT = 64
) (
    input  logic                             clk,
    input  logic                             rst_n,
    // tdata: key_index[5:0], travel[13:6], trip_point[21:14],
    // press_delta[29:22], release_delta[37:30], continuous[38], zero[39]
    input  logic                             s_axis_tvalid,
    output logic                             s_axis_tready,
    input  logic [rtka_pkg::IN_TDATA_W-1:0]  s_axis_tdata,
    // tdata: key_out[5:0], pressed[6], direction[8:7], zero[15:9]
    output logic                             m_axis_tvalid,
    input  logic                             m_axis_tready,
    output logic [rtka_pkg::OUT_TDATA_W-1:0] m_axis_tdata
);
    import rtka_pkg::*;

    localparam int AW = (KEY_COUNT > 1) ? $clog2(KEY_COUNT) : 1;

    // Input field split.
    logic [KEY_W-1:0]    in_key;
    sample_t             in_sample;
    logic [KEY_W+AW-1:0] in_key_wide;
    logic [AW-1:0]       in_addr;
    logic                in_range;
    logic                in_xfer;

    // Stage 1: sample waiting for its state read.
    logic                s1_valid_reg;
    logic [KEY_W-1:0]    s1_key_reg;
    logic [AW-1:0]       s1_addr_reg;
    logic                s1_range_reg;
    sample_t             s1_sample_reg;
    logic                s1_init_reg;
    logic                s1_fwd_hit_reg;
    key_entry_t          s1_fwd_state_reg;
    logic                s1_adv;
    logic                s1_we;

    // State memory and per-key valid flags.
    logic [KEY_COUNT-1:0] key_valid_reg;
    logic [KEY_COUNT-1:0] key_valid_next;
    logic [STATE_W-1:0]   ram_rdata;
    key_entry_t           cur_state;
    key_entry_t           next_state;

    // Output register.
    logic             out_valid_reg;
    logic [KEY_W-1:0] out_key_reg;
    logic             out_pressed_reg;
    dir_t             out_dir_reg;

    assign in_key                    = s_axis_tdata[5:0];
    assign in_sample.travel          = s_axis_tdata[13:6];
    assign in_sample.trip_point      = s_axis_tdata[21:14];
    assign in_sample.press_delta     = s_axis_tdata[29:22];
    assign in_sample.release_delta   = s_axis_tdata[37:30];
    assign in_sample.continuous      = s_axis_tdata[38];

    // Map the key number onto the memory address.
    assign in_key_wide = {{AW{1'b0}}, in_key};
    assign in_addr     = in_key_wide[AW-1:0];
    assign in_range    = ({3'b000, in_key} < 9'(KEY_COUNT));

    // Handshake: stage 1 moves on whenever the output register is free or drained.
    assign s1_adv        = !out_valid_reg || m_axis_tready;
    assign s_axis_tready = !s1_valid_reg || s1_adv;
    assign in_xfer       = s_axis_tvalid && s_axis_tready;
    assign s1_we         = s1_valid_reg && s1_adv && s1_range_reg;

    rtka_ram #(
        .WIDTH (STATE_W),
        .DEPTH (KEY_COUNT),
        .AW    (AW)
    ) u_state_ram (
        .clk   (clk),
        .we    (s1_we),
        .waddr (s1_addr_reg),
        .wdata (next_state),
        .re    (in_xfer && in_range),
        .raddr (in_addr),
        .rdata (ram_rdata)
    );

    // Current state: forwarded write, reset value for a key never written, or memory.
    always_comb
    begin
        if (s1_fwd_hit_reg)
        begin
            cur_state = s1_fwd_state_reg;
        end
        else if (!s1_init_reg)
        begin
            cur_state           = '0;
            cur_state.direction = DIR_INACTIVE;
        end
        else
        begin
            cur_state = key_entry_t'(ram_rdata);
        end
    end

    rtka_update u_update (
        .cur_state  (cur_state),
        .sample     (s1_sample_reg),
        .next_state (next_state)
    );

    // Valid flag of a key is set by its first write.
    always_comb
    begin
        key_valid_next = key_valid_reg;
        if (s1_we)
        begin
            key_valid_next[s1_addr_reg] = 1'b1;
        end
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            key_valid_reg <= '0;
        end
        else
        begin
            key_valid_reg <= key_valid_next;
            if (in_xfer)
            begin
                s1_valid_reg <= 1'b1;
            end
            else if (s1_adv)
            begin
                s1_valid_reg <= 1'b0;
            end
            if (s1_valid_reg && s1_adv)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_axis_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Stage 1 payload, with the write of the same cycle captured for forwarding.
    always_ff @(posedge clk)
    begin
        if (in_xfer)
        begin
            s1_key_reg       <= in_key;
            s1_addr_reg      <= in_addr;
            s1_range_reg     <= in_range;
            s1_sample_reg    <= in_sample;
            s1_init_reg      <= in_range && key_valid_reg[in_addr];
            s1_fwd_hit_reg   <= in_range && s1_we && (s1_addr_reg == in_addr);
            s1_fwd_state_reg <= next_state;
        end
    end

    // Output payload; an out-of-range key reports released and inactive.
    always_ff @(posedge clk)
    begin
        if (s1_valid_reg && s1_adv)
        begin
            out_key_reg <= s1_key_reg;
            if (s1_range_reg)
            begin
                out_pressed_reg <= next_state.pressed;
                out_dir_reg     <= next_state.direction;
            end
            else
            begin
                out_pressed_reg <= 1'b0;
                out_dir_reg     <= DIR_INACTIVE;
            end
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {7'b0000000, out_dir_reg, out_pressed_reg, out_key_reg};

    // A key moving down is always pressed, a key moving up never is.
    `RTKA_ASSERT_SAME(a_down_pressed, clk, rst_n,
        out_valid_reg && (out_dir_reg == DIR_DOWN), out_pressed_reg)
    `RTKA_ASSERT_SAME(a_up_released, clk, rst_n,
        out_valid_reg && (out_dir_reg == DIR_UP), !out_pressed_reg)
    // Every sample transfer lands in stage 1.
    `RTKA_ASSERT_NEXT(a_xfer_to_s1, clk, rst_n, in_xfer, s1_valid_reg)
    // A result held back by the output side leaves its state write undone.
    `RTKA_ASSERT_SAME(a_write_on_advance, clk, rst_n,
        s1_we, s1_valid_reg && (!out_valid_reg || m_axis_tready))

endmodule

@@ sim/tb.sv @@
// Self-checking testbench of the rapid-trigger key actuation block over its sample and result streams.
module tb;

    timeunit 1ns;
    timeprecision 1ps;

    import rtka_pkg::*;

    localparam int KEYS = 64;

    // Expected content of one result transfer.
    typedef struct {
        logic [KEY_W-1:0] key;
        logic             pressed;
        dir_t             direction;
    } key_result_t;

    logic                   clk = 1'b0;
    logic                   rst_n = 1'b0;
    logic                   s_axis_tvalid = 1'b0;
    logic                   s_axis_tready;
    logic [IN_TDATA_W-1:0]  s_axis_tdata = '0;
    logic                   m_axis_tvalid;
    logic                   m_axis_tready = 1'b0;
    logic [OUT_TDATA_W-1:0] m_axis_tdata;

    // Predicted per-key state, cleared like the block at reset.
    dir_t              key_dir [KEYS];
    logic [DIST_W-1:0] key_ext [KEYS];
    logic              key_prs [KEYS];

    key_result_t pending_results[$];
    int          mismatches = 0;
    int          gap_pct = 0;
    int          stall_pct = 0;
    int          hold_left = 0;

    rapid_trigger_key_actuation #(
        .KEY_COUNT(KEYS)
    ) dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata (s_axis_tdata),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata (m_axis_tdata)
    );

    always #1 clk = ~clk;

    // Receiver: a long hold-off when one is requested, random stalls otherwise.
    always @(posedge clk)
    begin
        if (hold_left > 0)
        begin
            m_axis_tready <= 1'b0;
            hold_left = hold_left - 1;
        end
        else
        begin
            m_axis_tready <= ($urandom_range(99) >= stall_pct);
        end
    end

    // Moves one key to a new state of its rapid-trigger machine.
    function automatic void move_key(input logic [KEY_W-1:0] key, input logic [DIST_W-1:0] travel,
                                     input dir_t dir, input logic pressed);
        key_ext[key] = travel;
        key_dir[key] = dir;
        key_prs[key] = pressed;
    endfunction

    // Advances the predicted state of one key by one sample and returns the result.
    function automatic key_result_t actuate_key(input logic [KEY_W-1:0] key, input sample_t s);
        key_result_t       r;
        logic [DIST_W-1:0] reset_pt;
        logic [DIST_W-1:0] rel_step;
        logic [DIST_W-1:0] ext;
        r.key = key;
        if (s.press_delta == '0)
        begin
            // Standard mode: plain threshold, extremum left alone.
            key_prs[key] = (s.travel >= s.trip_point);
            key_dir[key] = DIR_INACTIVE;
        end
        else
        begin
            reset_pt = ((s.continuous & CONTINUOUS_BIT) != 1'b0) ? '0 : s.trip_point;
            rel_step = (s.release_delta != '0) ? s.release_delta : s.press_delta;
            ext = key_ext[key];
            case (key_dir[key])
                DIR_DOWN:
                begin
                    if (s.travel <= reset_pt)
                        move_key(key, s.travel, DIR_INACTIVE, 1'b0);
                    else if (ext >= rel_step && s.travel <= ext - rel_step)
                        move_key(key, s.travel, DIR_UP, 1'b0);
                    else if (s.travel > ext)
                        key_ext[key] = s.travel;
                end
                DIR_UP:
                begin
                    // The press test uses a 9-bit sum so that it cannot wrap.
                    if (s.travel <= reset_pt)
                        move_key(key, s.travel, DIR_INACTIVE, 1'b0);
                    else if (9'(ext) + 9'(s.press_delta) <= 9'(s.travel))
                        move_key(key, s.travel, DIR_DOWN, 1'b1);
                    else if (s.travel < ext)
                        key_ext[key] = s.travel;
                end
                default:
                begin
                    if (s.travel > s.trip_point)
                        move_key(key, s.travel, DIR_DOWN, 1'b1);
                end
            endcase
        end
        r.pressed = key_prs[key];
        r.direction = key_dir[key];
        return r;
    endfunction

    // Offers one sample, waits for its transfer and records the expected result.
    task automatic send_sample(input logic [KEY_W-1:0] key, input logic [DIST_W-1:0] travel,
                               input logic [DIST_W-1:0] act, input logic [DIST_W-1:0] pd,
                               input logic [DIST_W-1:0] rd, input logic cont);
        sample_t s;
        s = '{travel: travel, trip_point: act, press_delta: pd,
              release_delta: rd, continuous: cont};
        // Each cycle the sender stays idle with the chance given by gap_pct.
        while ($urandom_range(99) < gap_pct)
        begin
            s_axis_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= {1'b0, cont, rd, pd, act, travel, key};
        @(posedge clk);
        while (!s_axis_tready) @(posedge clk);
        pending_results.push_back(actuate_key(key, s));
    endtask

    // Stops offering samples and waits until every expected result has arrived.
    task automatic drain_results();
        s_axis_tvalid <= 1'b0;
        do @(posedge clk); while (pending_results.size() != 0);
    endtask

    // Settings of one key as a random scan would give them.
    function automatic sample_t random_settings();
        sample_t s;
        s.travel = '0;
        s.trip_point = ($urandom_range(99) < 10) ? 8'($urandom) : 8'($urandom_range(10, 150));
        if ($urandom_range(99) < 10)
            s.press_delta = '0;
        else if ($urandom_range(99) < 10)
            s.press_delta = 8'($urandom_range(41, 255));
        else
            s.press_delta = 8'($urandom_range(1, 40));
        s.release_delta = ($urandom_range(99) < 30) ? 8'd0 : 8'($urandom_range(1, 60));
        s.continuous = 1'($urandom_range(0, 1));
        return s;
    endfunction

    // Standard threshold mode at the extremes of the fields.
    task automatic test_standard_mode();
        send_sample(6'd0, 8'd255, 8'd255, 8'd0, 8'd0, 1'b0);
        send_sample(6'd63, 8'd0, 8'd0, 8'd0, 8'd255, 1'b1);
        send_sample(6'd63, 8'd0, 8'd1, 8'd0, 8'd0, 1'b0);
        drain_results();
    endtask

    // Walks keys through every transition of the rapid-trigger machine.
    task automatic test_rapid_trigger();
        // Release step taken from the press delta, reset at the actuation point.
        send_sample(6'd1, 8'd101, 8'd100, 8'd10, 8'd0, 1'b0);
        send_sample(6'd1, 8'd150, 8'd100, 8'd10, 8'd0, 1'b0);
        send_sample(6'd1, 8'd140, 8'd100, 8'd10, 8'd0, 1'b0);
        send_sample(6'd1, 8'd150, 8'd100, 8'd10, 8'd0, 1'b0);
        send_sample(6'd1, 8'd100, 8'd100, 8'd10, 8'd0, 1'b0);
        // Continuous mode: only a return to rest makes the key inactive.
        send_sample(6'd2, 8'd60, 8'd50, 8'd20, 8'd5, 1'b1);
        send_sample(6'd2, 8'd30, 8'd50, 8'd20, 8'd5, 1'b1);
        send_sample(6'd2, 8'd10, 8'd50, 8'd20, 8'd5, 1'b1);
        send_sample(6'd2, 8'd0, 8'd50, 8'd20, 8'd5, 1'b1);
        // Largest deltas: the release can never be reached from full travel.
        send_sample(6'd3, 8'd255, 8'd0, 8'd255, 8'd255, 1'b0);
        send_sample(6'd3, 8'd1, 8'd0, 8'd255, 8'd255, 1'b0);
        send_sample(6'd3, 8'd0, 8'd0, 8'd255, 8'd255, 1'b0);
        // Press test near full travel must not wrap.
        send_sample(6'd4, 8'd200, 8'd10, 8'd100, 8'd3, 1'b1);
        send_sample(6'd4, 8'd197, 8'd10, 8'd100, 8'd3, 1'b1);
        send_sample(6'd4, 8'd255, 8'd10, 8'd100, 8'd3, 1'b1);
        send_sample(6'd4, 8'd150, 8'd10, 8'd100, 8'd3, 1'b1);
        send_sample(6'd4, 8'd250, 8'd10, 8'd100, 8'd3, 1'b1);
        // Extremum smaller than the release step: the key stays down.
        send_sample(6'd5, 8'd5, 8'd0, 8'd10, 8'd20, 1'b0);
        send_sample(6'd5, 8'd1, 8'd0, 8'd10, 8'd20, 1'b0);
        // Switch to standard mode and back; the extremum survives.
        send_sample(6'd5, 8'd1, 8'd3, 8'd0, 8'd20, 1'b0);
        send_sample(6'd5, 8'd4, 8'd0, 8'd10, 8'd20, 1'b1);
        drain_results();
    endtask

    // Random travel walks on a few keys, mixed with fully random samples.
    task automatic test_random_walk(input int items);
        logic [KEY_W-1:0] key_of [4];
        sample_t          set_of [4];
        int               slot;
        int               pos;
        slot = 0;
        for (int k = 0; k < 4; k++)
        begin
            key_of[k] = 6'($urandom_range(0, 63));
            set_of[k] = random_settings();
        end
        for (int n = 0; n < items; n++)
        begin
            if ($urandom_range(99) < 10)
            begin
                send_sample(6'($urandom), 8'($urandom), 8'($urandom), 8'($urandom),
                            8'($urandom), 1'($urandom));
                continue;
            end
            if ($urandom_range(99) < 50)
                slot = $urandom_range(0, 3);
            if ($urandom_range(99) < 3)
            begin
                key_of[slot] = 6'($urandom_range(0, 63));
                set_of[slot] = random_settings();
            end
            // Mostly small steps, now and then a jump to rest, full travel or anywhere.
            if ($urandom_range(99) < 5)
                pos = ($urandom_range(0, 2) == 0) ? 0 : (($urandom_range(0, 1) == 0) ? 255
                                                                : int'($urandom_range(0, 255)));
            else
                pos = int'(set_of[slot].travel) + int'($urandom_range(0, 60)) - 30;
            if (pos < 0)
                pos = 0;
            if (pos > 255)
                pos = 255;
            set_of[slot].travel = 8'(pos);
            send_sample(key_of[slot], set_of[slot].travel, set_of[slot].trip_point,
                        set_of[slot].press_delta, set_of[slot].release_delta,
                        set_of[slot].continuous);
        end
        drain_results();
    endtask

    // Receiver holds off while samples keep coming, then the sender waits for all results.
    task automatic test_backpressure();
        gap_pct = 0;
        stall_pct = 0;
        hold_left = 150;
        test_random_walk(60);
        test_random_walk(20);
    endtask

    // Result checker: every result transfer is matched to the oldest expectation.
    always @(posedge clk)
    begin : check_results
        key_result_t want;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            if (pending_results.size() == 0)
            begin
                $error("result transfer with no sample outstanding: tdata=%h", m_axis_tdata);
                mismatches++;
            end
            else
            begin
                want = pending_results.pop_front();
                if (m_axis_tdata[5:0] !== want.key)
                begin
                    $error("key_out: expected %0d, got %0d", want.key, m_axis_tdata[5:0]);
                    mismatches++;
                end
                if (m_axis_tdata[6] !== want.pressed)
                begin
                    $error("pressed: expected %0d, got %0d", want.pressed, m_axis_tdata[6]);
                    mismatches++;
                end
                if (m_axis_tdata[8:7] !== want.direction)
                begin
                    $error("direction: expected %0d, got %0d", want.direction,
                           m_axis_tdata[8:7]);
                    mismatches++;
                end
            end
        end
    end

    // Run watchdog.
    initial
    begin
        #2000000;
        $display("tb: FAIL");
        $finish;
    end

    // Test sequence.
    initial
    begin
        for (int k = 0; k < KEYS; k++)
            move_key(6'(k), '0, DIR_INACTIVE, 1'b0);
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_standard_mode();
        test_rapid_trigger();

        gap_pct = 0;
        stall_pct = 0;
        test_random_walk(500);
        gap_pct = 81;
        stall_pct = 0;
        test_random_walk(450);
        gap_pct = 0;
        stall_pct = 81;
        test_random_walk(450);
        gap_pct = 36;
        stall_pct = 36;
        test_random_walk(450);

        test_backpressure();

        gap_pct = 0;
        stall_pct = 0;
        repeat (10) @(posedge clk);
        if (mismatches == 0 && pending_results.size() == 0)
            $display("tb: PASS");
        else
            $display("tb: FAIL");
        $finish;
    end

endmodule
